>>> hdl/mjpr_pkg.sv
// Shared types and constants for the maze junction path recorder.
package mjpr_pkg;

  // Default depth of the path stack.
  localparam int PATH_DEPTH_DEF = 256;

  // Width of the path length field in a result.
  localparam int PLEN_W = 9;

  // Widths of the stream payloads.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes.
  localparam logic CFG_RUN_MODE  = 1'b0;
  localparam logic CFG_HAND_RULE = 1'b1;

  // Run modes and hand rules.
  localparam logic MODE_MAP    = 1'b0;
  localparam logic MODE_REPLAY = 1'b1;
  localparam logic HAND_RIGHT  = 1'b0;
  localparam logic HAND_LEFT   = 1'b1;

  // Compass headings and relative turns.
  localparam logic [1:0] HEAD_NORTH    = 2'd0;
  localparam logic [1:0] TURN_STRAIGHT = 2'd0;
  localparam logic [1:0] TURN_RIGHT    = 2'd1;
  localparam logic [1:0] TURN_ABOUT    = 2'd2;
  localparam logic [1:0] TURN_LEFT     = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_A,
    S_RD_B,
    S_REPLAY
  } ctl_state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_HOLD,
    OP_GOAL,
    OP_OVF,
    OP_PUSH,
    OP_RD_A,
    OP_EVAL,
    OP_RP_READ,
    OP_RP_TAKE,
    OP_RDONE
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load_in;
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;
    logic finished;
    logic goal;
    logic map_mode;
    logic full;
    logic ge2;
    logic avail;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/maze_junction_path_recorder_core.sv
// Top level of the maze junction path recorder.
//
// Input stream: one transaction per maze event. s_tuser is the action
// (0 junction event, 1 start a new session); s_tdata carries the sensor flags.
// Output stream: one result transaction per input transaction, in order.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 run mode,
// 1 hand rule); write only while no item is in flight.
// Sequence: the result of a start, goal, finished, overflow or exhausted replay
// item and of a push onto fewer than two entries is loaded from S_EXEC; a replay
// step passes through S_EXEC and S_REPLAY, and a mapping push that checks for
// path shortening passes through S_EXEC, S_RD_A and S_RD_B.
// The controller returns to S_IDLE with each item before it takes the next; the
// registered read of the path memory sets the longer sequences.
// A new item is taken in the cycle its predecessor's result is taken or later.
// While the receiver stalls the result holds and no new item is taken.
// Reset clears heading, counters, the finished flag and both registers; the
// path memory is not cleared and needs no clearing pass.
module maze_junction_path_recorder_core import mjpr_pkg::*; #(
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic                   cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // left_open, right_open, straight_open, dead_end, at_goal, zero padding
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // turn[1:0], heading[3:2], path_length[12:4], goal_reached, replay_done, overflow
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mjpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mjpr_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
  );

endmodule

>>> hdl/mjpr_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module mjpr_ctrl import mjpr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.start || stat.finished || stat.goal) begin
          state_next = S_IDLE;
        end else if (stat.map_mode) begin
          state_next = (!stat.full && stat.ge2) ? S_RD_A : S_IDLE;
        end else begin
          state_next = stat.avail ? S_REPLAY : S_IDLE;
        end
      end
      S_RD_A:   state_next = S_RD_B;
      S_RD_B:   state_next = S_IDLE;
      S_REPLAY: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs: the operation for each state and the input handshake.
  always_comb begin
    s_tready     = (state == S_IDLE) && stat.out_free;
    cmd.load_in  = s_tvalid && s_tready;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.op = OP_NONE;
      end
      S_EXEC: begin
        cmd.load_out = 1'b1;
        if (stat.start) begin
          cmd.op = OP_START;
        end else if (stat.finished) begin
          cmd.op = OP_HOLD;
        end else if (stat.goal) begin
          cmd.op = OP_GOAL;
        end else if (stat.map_mode) begin
          if (stat.full) begin
            cmd.op = OP_OVF;
          end else begin
            cmd.op       = OP_PUSH;
            cmd.load_out = !stat.ge2;
          end
        end else if (stat.avail) begin
          cmd.op       = OP_RP_READ;
          cmd.load_out = 1'b0;
        end else begin
          cmd.op = OP_RDONE;
        end
      end
      S_RD_A: begin
        cmd.op = OP_RD_A;
      end
      S_RD_B: begin
        cmd.op       = OP_EVAL;
        cmd.load_out = 1'b1;
      end
      S_REPLAY: begin
        cmd.op       = OP_RP_TAKE;
        cmd.load_out = 1'b1;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

>>> hdl/mjpr_dp.sv
// Datapath: heading, path stack memory, counters and the result register.
module mjpr_dp import mjpr_pkg::*; #(
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic                   cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);

  // Configuration registers.
  logic run_mode, hand_rule;

  // Latched item.
  logic item_start, item_left, item_right, item_straight, item_dead, item_goal;

  // Run state.
  logic [1:0]    heading, heading_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic          fin, fin_next;
  logic [1:0]    turn_r, turn_r_next;
  logic [1:0]    a_r, a_next;

  // Path stack memory.
  logic [1:0]    path_mem [PATH_DEPTH];
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    wdata, rdata;

  // Decision and result values.
  logic [1:0]    abs_r, abs_l, abs_b, chosen;
  logic [1:0]    turn_res;
  logic          rdone_res, ovf_res;
  logic [AW-1:0] count_m1, count_m2;
  logic [CW+PLEN_W-1:0] cnt_ext;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode  <= MODE_MAP;
      hand_rule <= HAND_RIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RUN_MODE:  run_mode  <= cfg_wdata;
        CFG_HAND_RULE: hand_rule <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Item register, loaded on each input transaction.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_start    <= s_tuser;
      item_left     <= s_tdata[0];
      item_right    <= s_tdata[1];
      item_straight <= s_tdata[2];
      item_dead     <= s_tdata[3];
      item_goal     <= s_tdata[4];
    end
  end

  // Exit choice by the selected hand rule; a dead end or no exit turns back.
  always_comb begin
    abs_r = heading + TURN_RIGHT;
    abs_l = heading + TURN_LEFT;
    abs_b = heading + TURN_ABOUT;
    if (item_dead) begin
      chosen = abs_b;
    end else if (hand_rule == HAND_LEFT) begin
      if (item_left)          chosen = abs_l;
      else if (item_straight) chosen = heading;
      else if (item_right)    chosen = abs_r;
      else                    chosen = abs_b;
    end else begin
      if (item_right)         chosen = abs_r;
      else if (item_straight) chosen = heading;
      else if (item_left)     chosen = abs_l;
      else                    chosen = abs_b;
    end
  end

  assign count_m1 = AW'(count - CW'(1));
  assign count_m2 = AW'(count - CW'(2));

  // Operation decode.
  always_comb begin
    heading_next = heading;
    count_next   = count;
    pos_next     = pos;
    fin_next     = fin;
    turn_r_next  = turn_r;
    a_next       = a_r;
    turn_res     = TURN_STRAIGHT;
    rdone_res    = 1'b0;
    ovf_res      = 1'b0;
    mem_we       = 1'b0;
    waddr        = count[AW-1:0];
    wdata        = chosen;
    raddr        = count_m2;
    unique case (cmd.op)
      OP_NONE: ;
      OP_START: begin
        heading_next = HEAD_NORTH;
        pos_next     = '0;
        fin_next     = 1'b0;
        if (run_mode == MODE_MAP) count_next = '0;
      end
      OP_HOLD: ;
      OP_GOAL: begin
        fin_next = 1'b1;
      end
      OP_OVF: begin
        heading_next = chosen;
        turn_res     = chosen - heading;
        ovf_res      = 1'b1;
      end
      OP_PUSH: begin
        // Store the heading; a read of the entry two below starts the shortening check.
        mem_we       = 1'b1;
        heading_next = chosen;
        turn_res     = chosen - heading;
        turn_r_next  = chosen - heading;
        if (!stat.ge2) count_next = count + CW'(1);
      end
      OP_RD_A: begin
        a_next = rdata;
        raddr  = count_m1;
      end
      OP_EVAL: begin
        // A heading followed by its reverse collapses to the newest heading.
        turn_res = turn_r;
        if (2'(a_r + TURN_ABOUT) == rdata) begin
          mem_we     = 1'b1;
          waddr      = count_m2;
          wdata      = heading;
          count_next = count - CW'(1);
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_RP_READ: begin
        raddr = pos[AW-1:0];
      end
      OP_RP_TAKE: begin
        heading_next = rdata;
        turn_res     = rdata - heading;
        pos_next     = pos + CW'(1);
      end
      OP_RDONE: begin
        rdone_res = 1'b1;
      end
      default: ;
    endcase
  end

  // Run state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= HEAD_NORTH;
      count   <= '0;
      pos     <= '0;
      fin     <= 1'b0;
    end else begin
      heading <= heading_next;
      count   <= count_next;
      pos     <= pos_next;
      fin     <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    turn_r <= turn_r_next;
    a_r    <= a_next;
  end

  // Path memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) path_mem[waddr] <= wdata;
    rdata <= path_mem[raddr];
  end

  // Result register; a new result is loaded only when the slot is free.
  assign cnt_ext = {{PLEN_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {ovf_res, rdone_res, fin_next, cnt_ext[PLEN_W-1:0], heading_next, turn_res};
    end
  end

  // Status to the controller.
  always_comb begin
    stat.start    = item_start;
    stat.finished = fin;
    stat.goal     = item_goal && !item_dead;
    stat.map_mode = (run_mode == MODE_MAP);
    stat.full     = (count == CW'(PATH_DEPTH));
    stat.ge2      = (count >= CW'(2));
    stat.avail    = (pos < count);
    stat.out_free = !m_tvalid || m_tready;
  end

endmodule
